### rtl/vrt_pkg.sv
// shared types and constants of the voxel ray traversal unit
package vrt_pkg;

    localparam int IDX_W = 24;
    localparam int T_W = 40;
    localparam int SIZE_W = 32;
    localparam int T_FRAC = 32;

    localparam logic [T_W-1:0] CROSS_MAX = {T_W{1'b1}};
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
    localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLOOR,
        S_TDIV,
        S_WALK
    } t_state;

    typedef struct packed {
        logic load;
        logic tdiv_start;
        logic walk_init;
        logic walk_step;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic walk_end;
    } t_stat;

endpackage

### rtl/vrt_div.sv
// restoring long divider, one quotient bit per cycle
module vrt_div #(
    parameter int NW = 40,
    parameter int DW = 33
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DW-1:0]            i_rem0,
    input  logic [DW-1:0]            i_den,
    input  logic [NW-1:0]            i_num,
    input  logic [$clog2(NW+1)-1:0]  i_steps,
    output logic [NW-1:0]            o_quo,
    output logic [DW-1:0]            o_rem,
    output logic                     o_done
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;
    logic [DW:0]   sh;
    logic          ge;

    assign sh = {r_rem, r_num[NW-1]};
    assign ge = sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= i_steps;
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_den <= i_den;
            r_num <= i_num;
            r_quo <= '0;
        end else if (r_run) begin
            r_rem <= ge ? DW'(sh - {1'b0, r_den}) : sh[DW-1:0];
            r_num <= r_num << 1;
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;
endmodule

### rtl/vrt_datapath.sv
// setup dividers, traversal registers and result registers
module vrt_datapath #(
    parameter int MAX_VOXELS = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vrt_pkg::t_cmd                 i_cmd,
    output vrt_pkg::t_stat                o_stat,
    input  logic                          i_size_we,
    input  logic [vrt_pkg::SIZE_W-1:0]    i_size,
    input  logic signed [COORD_WIDTH-1:0] i_org [3],
    input  logic signed [COORD_WIDTH-1:0] i_end [3],
    output logic [vrt_pkg::IDX_W-1:0]     o_vox [3],
    output logic                          o_last,
    output logic                          o_truncated,
    output logic                          o_valid
);
    localparam int NW = (COORD_WIDTH > 40) ? COORD_WIDTH : 40;
    localparam int DW = (COORD_WIDTH + 1 > 33) ? COORD_WIDTH + 1 : 33;
    localparam int SW = $clog2(NW + 1);
    localparam int KW = $clog2(MAX_VOXELS + 1);
    localparam int IW = vrt_pkg::IDX_W;
    localparam int TW = vrt_pkg::T_W;
    localparam int ZW = vrt_pkg::SIZE_W;

    logic [ZW-1:0] r_voxel_size;
    logic [ZW-1:0] r_size_eff;
    logic [ZW-1:0] size_eff;
    logic [KW-1:0] r_count;

    logic signed [COORD_WIDTH-1:0] r_o [3];
    logic signed [COORD_WIDTH-1:0] r_e [3];
    logic [IW-1:0] r_cur [3];
    logic [IW-1:0] r_endv [3];
    logic [TW-1:0] r_nc [3];
    logic [TW-1:0] r_cs [3];
    logic          r_neg [3];
    logic          r_sat0 [3];
    logic          r_sat1 [3];
    logic [6:0]    done_vec;

    logic [IW-1:0] r_vox [3];
    logic          r_last;
    logic          r_trunc;
    logic          r_valid;

    logic [TW:0]   sum [3];
    logic [2:0]    sel;
    logic [TW-1:0] tmin;
    logic          at_end, stop, trunc;

    assign size_eff = (r_voxel_size < vrt_pkg::MIN_SIZE) ? vrt_pkg::MIN_SIZE : r_voxel_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voxel_size <= vrt_pkg::SIZE_RESET;
        end else if (i_size_we) begin
            r_voxel_size <= i_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_size_eff <= size_eff;
        end
    end

    assign done_vec[6] = 1'b1;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [COORD_WIDTH-1:0] uo, ue;
        logic [NW-1:0] q0, q1;
        logic [DW-1:0] rm0, rm1;
        logic          dn0, dn1;
        logic          st0, st1;
        logic [DW-1:0] rz0, rz1, den;
        logic [NW-1:0] nm0, nm1;
        logic [SW-1:0] steps;
        logic signed [COORD_WIDTH:0] d;
        logic          dneg;
        logic [COORD_WIDTH:0] ad;
        logic [ZW-1:0] ro, rs;
        logic [32:0]   bnd;
        logic [32:0]   xs;
        logic [IW-1:0] io, ie;

        assign uo = i_org[a][COORD_WIDTH-1] ? ~i_org[a] : i_org[a];
        assign ue = i_end[a][COORD_WIDTH-1] ? ~i_end[a] : i_end[a];

        assign d    = (COORD_WIDTH+1)'(r_e[a]) - (COORD_WIDTH+1)'(r_o[a]);
        assign dneg = d[COORD_WIDTH];
        assign ad   = dneg ? (COORD_WIDTH+1)'(-d) : (COORD_WIDTH+1)'(d);

        assign rs   = rm0[ZW-1:0];
        assign ro   = r_o[a][COORD_WIDTH-1] ? (r_size_eff - ZW'(1) - rs) : rs;
        assign io   = r_o[a][COORD_WIDTH-1] ? ~q0[IW-1:0] : q0[IW-1:0];
        assign ie   = r_e[a][COORD_WIDTH-1] ? ~q1[IW-1:0] : q1[IW-1:0];
        assign bnd  = dneg ? {1'b0, ro} : ({1'b0, r_size_eff} - {1'b0, ro});
        assign xs   = {1'b0, r_size_eff};

        assign st0 = i_cmd.load || i_cmd.tdiv_start;
        assign st1 = st0;
        assign den = i_cmd.load ? DW'(size_eff) : DW'(ad);
        assign rz0 = i_cmd.load ? '0 : DW'(bnd >> 8);
        assign rz1 = i_cmd.load ? '0 : DW'(xs >> 8);
        assign nm0 = i_cmd.load ? (NW'(uo) << (NW - COORD_WIDTH))
                                : (NW'({bnd[7:0], 32'b0}) << (NW - 40));
        assign nm1 = i_cmd.load ? (NW'(ue) << (NW - COORD_WIDTH))
                                : (NW'({xs[7:0], 32'b0}) << (NW - 40));
        assign steps = i_cmd.load ? SW'(COORD_WIDTH) : SW'(40);

        vrt_div #(.NW(NW), .DW(DW)) u_div0 (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(st0), .i_rem0(rz0), .i_den(den),
            .i_num(nm0), .i_steps(steps), .o_quo(q0), .o_rem(rm0), .o_done(dn0)
        );

        vrt_div #(.NW(NW), .DW(DW)) u_div1 (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(st1), .i_rem0(rz1), .i_den(den),
            .i_num(nm1), .i_steps(steps), .o_quo(q1), .o_rem(rm1), .o_done(dn1)
        );

        assign done_vec[2*a]   = dn0;
        assign done_vec[2*a+1] = dn1 && (rm1 == rm1);

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_o[a] <= i_org[a];
                r_e[a] <= i_end[a];
            end
            if (i_cmd.tdiv_start) begin
                r_cur[a]  <= io;
                r_endv[a] <= ie;
                r_neg[a]  <= dneg;
                r_sat0[a] <= (DW+1)'(bnd >> 8) >= (DW+1)'(ad);
                r_sat1[a] <= (DW+1)'(xs >> 8) >= (DW+1)'(ad);
            end
            if (i_cmd.walk_init) begin
                r_nc[a] <= r_sat0[a] ? vrt_pkg::CROSS_MAX : q0[TW-1:0];
                r_cs[a] <= r_sat1[a] ? vrt_pkg::CROSS_MAX : q1[TW-1:0];
            end else if (i_cmd.walk_step && sel[a]) begin
                r_nc[a]  <= sum[a][TW] ? vrt_pkg::CROSS_MAX : sum[a][TW-1:0];
                r_cur[a] <= r_neg[a] ? (r_cur[a] - IW'(1)) : (r_cur[a] + IW'(1));
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = {1'b0, r_nc[k]} + {1'b0, r_cs[k]};
        end
        tmin = r_nc[0];
        if (r_nc[1] < tmin) tmin = r_nc[1];
        if (r_nc[2] < tmin) tmin = r_nc[2];
        at_end = (r_cur[0] == r_endv[0]) && (r_cur[1] == r_endv[1]) &&
                 (r_cur[2] == r_endv[2]);
        stop  = at_end || (tmin > vrt_pkg::T_ONE);
        trunc = !stop && ((KW+1)'(r_count) + (KW+1)'(1) >= (KW+1)'(MAX_VOXELS));
        if (r_nc[0] < r_nc[1]) begin
            sel = (r_nc[0] < r_nc[2]) ? 3'b001 : 3'b100;
        end else begin
            sel = (r_nc[1] < r_nc[2]) ? 3'b010 : 3'b100;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.walk_step;
            if (i_cmd.walk_init) begin
                r_count <= '0;
            end else if (i_cmd.walk_step) begin
                r_count <= r_count + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step) begin
            r_vox   <= r_cur;
            r_last  <= stop || trunc;
            r_trunc <= trunc;
        end
    end

    assign o_stat.div_done = &done_vec;
    assign o_stat.walk_end = stop || trunc;
    assign o_vox       = r_vox;
    assign o_last      = r_last;
    assign o_truncated = r_trunc;
    assign o_valid     = r_valid;
endmodule

### rtl/vrt_ctrl.sv
// sequencing state machine of the voxel ray traversal unit
module vrt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  vrt_pkg::t_stat i_stat,
    output vrt_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    vrt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vrt_pkg::S_IDLE:  if (i_start) n_state = vrt_pkg::S_FLOOR;
            vrt_pkg::S_FLOOR: if (i_stat.div_done) n_state = vrt_pkg::S_TDIV;
            vrt_pkg::S_TDIV:  if (i_stat.div_done) n_state = vrt_pkg::S_WALK;
            vrt_pkg::S_WALK:  if (i_stat.walk_end) n_state = vrt_pkg::S_IDLE;
            default:          n_state = vrt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            vrt_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            vrt_pkg::S_FLOOR: o_cmd.tdiv_start = i_stat.div_done;
            vrt_pkg::S_TDIV:  o_cmd.walk_init = i_stat.div_done;
            vrt_pkg::S_WALK:  o_cmd.walk_step = 1'b1;
            default:          o_busy = 1'b0;
        endcase
    end
endmodule

### rtl/voxel_ray_traversal_unit.sv
// top level of the voxel ray traversal unit
// Takes one ray segment per start (accepted when start is high and busy low) and
// strobes out, one per cycle on o_valid, every voxel it crosses from origin to end.
// Setup runs two rounds of bit-serial division, first for the voxel indices and
// then for the crossing parameters; the walk then gives one voxel per cycle, up
// to MAX_VOXELS. Results cannot be held off: each is valid for exactly one cycle.
// The next ray may be started in the cycle that shows the last voxel of the
// previous one.
module voxel_ray_traversal_unit #(
    parameter int MAX_VOXELS = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_voxel_size_we,
    input  logic [31:0]                   i_voxel_size,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_z,
    output logic                          o_valid,
    output logic signed [23:0]            o_voxel_x,
    output logic signed [23:0]            o_voxel_y,
    output logic signed [23:0]            o_voxel_z,
    output logic                          o_last,
    output logic                          o_truncated
);
    vrt_pkg::t_cmd  cmd;
    vrt_pkg::t_stat stat;
    logic signed [COORD_WIDTH-1:0] org [3];
    logic signed [COORD_WIDTH-1:0] fin [3];
    logic [vrt_pkg::IDX_W-1:0]     vox [3];

    assign org = '{i_origin_x, i_origin_y, i_origin_z};
    assign fin = '{i_end_x, i_end_y, i_end_z};

    vrt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_stat(stat),
        .o_cmd(cmd), .o_busy(busy)
    );

    vrt_datapath #(.MAX_VOXELS(MAX_VOXELS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_size_we(i_voxel_size_we), .i_size(i_voxel_size),
        .i_org(org), .i_end(fin), .o_vox(vox), .o_last(o_last),
        .o_truncated(o_truncated), .o_valid(o_valid)
    );

    assign o_voxel_x = vox[0];
    assign o_voxel_y = vox[1];
    assign o_voxel_z = vox[2];
endmodule

### rtl/vrt_checker.sv
// port-level checks of the voxel ray traversal unit and their binding
module vrt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_last,
    input logic o_truncated
);
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_truncated |-> o_last) else $error("truncated word without last");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy) else $error("word mid ray while idle");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid) else $error("word right after last");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid) else $error("start not taken");
endmodule

bind voxel_ray_traversal_unit vrt_checker u_vrt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_last(o_last), .o_truncated(o_truncated)
);

### sim/voxel_ray_traversal_unit_tb.sv
// self-checking testbench of the voxel ray traversal unit
`timescale 1ns / 100ps

module voxel_ray_traversal_unit_tb;

    localparam int MAX_VOX = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;
    localparam int N_ROWS = 14;

    typedef struct {
        logic signed [31:0] org [3];
        logic signed [31:0] fin [3];
        logic               chk;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] vz;
    } t_ray_row;

    typedef struct packed {
        logic [23:0] vx;
        logic [23:0] vy;
        logic [23:0] vz;
        logic        last;
        logic        trunc;
    } t_voxel_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_voxel_size_we = 1'b0;
    logic [31:0] i_voxel_size = '0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [31:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic o_valid;
    logic signed [23:0] o_voxel_x, o_voxel_y, o_voxel_z;
    logic o_last, o_truncated;

    voxel_ray_traversal_unit #(.MAX_VOXELS(MAX_VOX), .COORD_WIDTH(32)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_voxel_size_we(i_voxel_size_we), .i_voxel_size(i_voxel_size),
        .start(start), .busy(busy),
        .i_origin_x(i_origin_x), .i_origin_y(i_origin_y), .i_origin_z(i_origin_z),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .i_end_z(i_end_z),
        .o_valid(o_valid), .o_voxel_x(o_voxel_x), .o_voxel_y(o_voxel_y),
        .o_voxel_z(o_voxel_z), .o_last(o_last), .o_truncated(o_truncated)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [31:0] size_reg = vrt_pkg::SIZE_RESET;
    t_voxel_word voxels_due [$];
    int errors = 0;
    int rays_sent = 0;
    int voxels_seen = 0;
    int truncs_seen = 0;
    int idle_cycles = 0;
    int sender_gap = 0;

    function automatic void queue_word(input t_voxel_word w);
        voxels_due = {voxels_due, w};
    endfunction

    function automatic logic [vrt_pkg::T_W-1:0] crossing_div(logic [71:0] num,
                                                             logic [32:0] den);
        logic [71:0] q;
        if (den == 0) return vrt_pkg::CROSS_MAX;
        q = num / den;
        return (q > 72'(vrt_pkg::CROSS_MAX)) ? vrt_pkg::CROSS_MAX : q[vrt_pkg::T_W-1:0];
    endfunction

    task automatic walk_ray(input logic signed [31:0] org [3],
                            input logic signed [31:0] fin [3]);
        logic [31:0] sz;
        logic signed [33:0] o, e, d, s, qo, qe, ro, re;
        logic [32:0] ad;
        logic [32:0] bnd;
        logic [23:0] cur [3], tgt [3];
        logic [vrt_pkg::T_W-1:0] nxt [3], stp [3], tmin;
        logic neg [3];
        logic at_end, stop, trunc;
        logic [vrt_pkg::T_W:0] sum;
        int cnt, ax;
        sz = (size_reg < vrt_pkg::MIN_SIZE) ? vrt_pkg::MIN_SIZE : size_reg;
        s = $signed({2'b00, sz});
        for (int a = 0; a < 3; a++) begin
            o = org[a];
            e = fin[a];
            d = e - o;
            qo = o / s; ro = o % s;
            if (ro < 0) begin qo = qo - 1; ro = ro + s; end
            qe = e / s; re = e % s;
            if (re < 0) begin qe = qe - 1; re = re + s; end
            ad = (d < 0) ? 33'(-d) : 33'(d);
            bnd = (d < 0) ? 33'(ro) : 33'(s - ro);
            cur[a] = qo[23:0];
            tgt[a] = qe[23:0];
            neg[a] = d < 0;
            nxt[a] = crossing_div({7'd0, bnd, 32'd0}, ad);
            stp[a] = crossing_div({7'd0, 1'b0, sz, 32'd0}, ad);
        end
        cnt = 0;
        forever begin
            at_end = cur[0] == tgt[0] && cur[1] == tgt[1] && cur[2] == tgt[2];
            tmin = nxt[0];
            if (nxt[1] < tmin) tmin = nxt[1];
            if (nxt[2] < tmin) tmin = nxt[2];
            stop = at_end || tmin > vrt_pkg::T_ONE;
            trunc = !stop && (cnt + 1 >= MAX_VOX);
            queue_word('{cur[0], cur[1], cur[2], stop || trunc, trunc});
            cnt++;
            if (stop || trunc) break;
            if (nxt[0] < nxt[1]) ax = (nxt[0] < nxt[2]) ? 0 : 2;
            else ax = (nxt[1] < nxt[2]) ? 1 : 2;
            cur[ax] = neg[ax] ? cur[ax] - 24'd1 : cur[ax] + 24'd1;
            sum = nxt[ax] + stp[ax];
            nxt[ax] = sum > vrt_pkg::CROSS_MAX ? vrt_pkg::CROSS_MAX : sum[vrt_pkg::T_W-1:0];
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid) begin
                t_voxel_word exp_w;
                voxels_seen <= voxels_seen + 1;
                if (o_truncated) truncs_seen <= truncs_seen + 1;
                if (voxels_due.size() == 0) begin
                    $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                             o_voxel_x, o_voxel_y, o_voxel_z);
                    errors <= errors + 1;
                end else begin
                    exp_w = voxels_due.pop_front();
                    if (exp_w != {o_voxel_x, o_voxel_y, o_voxel_z, o_last, o_truncated}) begin
                        $display("%0t: expected %0d %0d %0d last=%0b trunc=%0b, got %0d %0d %0d last=%0b trunc=%0b",
                                 $time, $signed(exp_w.vx), $signed(exp_w.vy), $signed(exp_w.vz),
                                 exp_w.last, exp_w.trunc, o_voxel_x, o_voxel_y, o_voxel_z,
                                 o_last, o_truncated);
                        errors <= errors + 1;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("voxel_ray_traversal_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic send_ray(input logic signed [31:0] org [3],
                            input logic signed [31:0] fin [3]);
        while (sender_gap > 0 && $urandom_range(99, 0) < sender_gap) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_origin_x <= org[0]; i_origin_y <= org[1]; i_origin_z <= org[2];
        i_end_x <= fin[0]; i_end_y <= fin[1]; i_end_z <= fin[2];
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        walk_ray(org, fin);
        rays_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (voxels_due.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [31:0] v);
        i_voxel_size_we <= 1'b1;
        i_voxel_size <= v;
        @(negedge i_clk);
        i_voxel_size_we <= 1'b0;
        size_reg = v;
    endtask

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(32'h0008_0000, 0)) - 32'sh0004_0000;
            default: return $signed($urandom_range(32'h0004_0000, 0)) - 32'sh0002_0000;
        endcase
    endfunction

    t_ray_row rows [N_ROWS];
    logic signed [31:0] ro3 [3], re3 [3];
    logic [31:0] sizes [6] = '{32'd256, 32'hFFFF_FFFF, 32'd0, 32'h0000_8000,
                                32'h0002_0000, vrt_pkg::SIZE_RESET};

    initial begin
        rows[0] = '{'{0, 0, 0}, '{0, 0, 0}, 1, 0, 0, 0};
        rows[1] = '{'{32'sh0001_8000, 0, 0}, '{32'sh0001_8000, 0, 0}, 1, 1, 0, 0};
        rows[2] = '{'{-32'sh0000_8000, 0, 0}, '{-32'sh0000_8000, 0, 0}, 1, -1, 0, 0};
        rows[3] = '{'{32'sh7FFF_FFFF, 32'sh8000_0000, 0},
                    '{32'sh7FFF_FFFF, 32'sh8000_0000, 0}, 1, 32767, -32768, 0};
        rows[4] = '{'{0, 0, 0}, '{32'sh0003_8000, 0, 0}, 0, 0, 0, 0};
        rows[5] = '{'{0, 0, 0}, '{0, -32'sh0003_8000, 0}, 0, 0, 0, 0};
        rows[6] = '{'{32'sh0001_0000, 0, 0}, '{-32'sh0000_8000, 0, 0}, 0, 0, 0, 0};
        rows[7] = '{'{0, 0, 0}, '{32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000},
                    0, 0, 0, 0};
        rows[8] = '{'{0, 0, 0}, '{32'sh0002_0000, 32'sh0002_0000, 0}, 0, 0, 0, 0};
        rows[9] = '{'{0, 0, 0}, '{32'sh0064_0000, 32'sh0032_0000, 32'sh0010_0000},
                    0, 0, 0, 0};
        rows[10] = '{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
                     '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 0, 0, 0, 0};
        rows[11] = '{'{32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF},
                     '{32'sh8000_0000, -1, 32'sh8000_0000}, 0, 0, 0, 0};
        rows[12] = '{'{-1, -1, -1}, '{1, 1, 1}, 0, 0, 0, 0};
        rows[13] = '{'{32'sh0000_4000, 32'sh0000_C000, 0},
                     '{-32'sh0002_4000, 32'sh0004_2000, -32'sh0001_1000}, 0, 0, 0, 0};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[r]) begin
            ro3 = rows[r].org; re3 = rows[r].fin;
            send_ray(ro3, re3);
            if (rows[r].chk) begin
                voxels_due[voxels_due.size() - 1] =
                    '{rows[r].vx, rows[r].vy, rows[r].vz, 1'b1, 1'b0};
            end
        end
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_size(sizes[ph]);
            sender_gap = (ph < 2) ? 7 : (ph < 4) ? 82 : 0;
            for (int n = 0; n < 66; n++) begin
                int mode;
                mode = $urandom_range(9, 0) == 0 ? 0 : $urandom_range(2, 1);
                for (int a = 0; a < 3; a++) begin
                    ro3[a] = rand_coord(mode);
                    re3[a] = ($urandom_range(7, 0) == 0) ? ro3[a] : rand_coord(mode);
                end
                send_ray(ro3, re3);
            end
            drain();
        end

        $display("rays %0d, voxel words %0d, truncated walks %0d, six voxel sizes",
                 rays_sent, voxels_seen, truncs_seen);
        if (errors == 0) begin
            $display("voxel_ray_traversal_unit: match");
        end else begin
            $display("voxel_ray_traversal_unit: mismatch");
        end
        $finish;
    end

endmodule
